// File: hw/rtl/tablet_packet_deframe_decode_defines.svh
// ----------------------------------------------------------------------------
// Tablet packet deframer: assertion macros
// Concurrent check wrappers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef TABLET_PACKET_DEFRAME_DECODE_DEFINES_SVH
`define TABLET_PACKET_DEFRAME_DECODE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TPDD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define TPDD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPDD_ASSERT(lbl, clk, rstn, prop, msg)
`define TPDD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hw/rtl/tpdd_pkg.sv
// ----------------------------------------------------------------------------
// Tablet packet deframer: package
// Shared constants and types for the deframer and report decoder.
// ----------------------------------------------------------------------------
package tpdd_pkg;

  localparam int PACKET_BYTES = 7;
  localparam int STORE_DEPTH  = PACKET_BYTES - 1;
  localparam int IDX_W        = $clog2(PACKET_BYTES);
  localparam int COORD_W      = 14;
  localparam int PRESS_W      = 7;

  localparam int SYNC_BIT     = 7;
  localparam int PROX_BIT     = 6;
  localparam int BTN1_BIT     = 4;
  localparam int BTN2_BIT     = 5;

  localparam logic [IDX_W-1:0]   IDX_IDLE      = '0;
  localparam logic [IDX_W-1:0]   IDX_LAST      = IDX_W'(PACKET_BYTES - 1);
  localparam logic [7:0]         PRESS_HI_LIM  = 8'h40;
  localparam logic [PRESS_W-1:0] PRESS_HI_ADD  = 7'h40;
  localparam logic [PRESS_W-1:0] THRESH_RESET  = 7'd15;

  typedef logic [7:0] pkt_byte_t;
  typedef pkt_byte_t [PACKET_BYTES-1:0] packet_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_position;
    logic [COORD_W-1:0] y_position;
    logic [PRESS_W-1:0] pressure;
    logic               left_button;
    logic               right_button;
    logic               in_proximity;
    logic               framing_error;
  } report_t;

endpackage

// File: hw/rtl/tpdd_byte_if.sv
// ----------------------------------------------------------------------------
// Tablet packet deframer: serial byte channel
// Valid/ready channel carrying one received serial byte per word.
// ----------------------------------------------------------------------------
interface tpdd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: hw/rtl/tpdd_report_if.sv
// ----------------------------------------------------------------------------
// Tablet packet deframer: report channel
// Valid/ready channel carrying one decoded pen report per word.
// ----------------------------------------------------------------------------
interface tpdd_report_if;
  logic        valid;
  logic        ready;
  logic [13:0] x_position;
  logic [13:0] y_position;
  logic [6:0]  pressure;
  logic        left_button;
  logic        right_button;
  logic        in_proximity;
  logic        framing_error;

  modport source (output valid, output x_position, output y_position, output pressure,
                  output left_button, output right_button, output in_proximity,
                  output framing_error, input ready);
  modport sink   (input valid, input x_position, input y_position, input pressure,
                  input left_button, input right_button, input in_proximity,
                  input framing_error, output ready);
endinterface

// File: hw/rtl/tpdd_report_decode.sv
// ----------------------------------------------------------------------------
// Tablet packet deframer: report decoder
// Turns a complete seven-byte packet into coordinates, pressure and buttons.
// ----------------------------------------------------------------------------
module tpdd_report_decode (
  input  tpdd_pkg::packet_t            packet,
  input  logic [tpdd_pkg::PRESS_W-1:0] threshold,
  output tpdd_pkg::report_t            report
);
  import tpdd_pkg::*;

  logic               prox;
  logic [COORD_W:0]   x_sum;
  logic [COORD_W:0]   y_sum;
  logic [PRESS_W-1:0] press;

  always_comb begin
    prox  = packet[0][PROX_BIT];
    x_sum = {packet[1], 7'b0} + {7'b0, packet[2]};
    y_sum = {packet[4], 7'b0} + {7'b0, packet[5]};
    press = {1'b0, packet[6][5:0]};
    if (prox && (packet[6] < PRESS_HI_LIM)) begin
      press = press + PRESS_HI_ADD;
    end

    report.x_position    = x_sum[COORD_W-1:0];
    report.y_position    = y_sum[COORD_W-1:0];
    report.pressure      = press;
    report.left_button   = packet[3][BTN1_BIT] | (press > threshold);
    report.right_button  = packet[3][BTN2_BIT];
    report.in_proximity  = prox;
    report.framing_error = 1'b0;
  end

endmodule

// File: hw/rtl/tablet_packet_deframe_decode.sv
// ----------------------------------------------------------------------------
// Tablet packet deframer and decoder
// Collects seven-byte pen packets from a serial byte stream and emits reports.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one received serial byte per word; bit 7 set marks a sync byte.
//   out_chan : one report per complete packet, or a framing-error word when a
//              non-sync byte arrives with no packet open (other fields zero).
//   cfg_wr_en/cfg_wr_data : pressure threshold; write only while idle.
// An accepted byte is registered, then decoded into the output register when
// it is free; its report is visible after that load. Throughput is one byte
// per cycle without a stall, set by the single input and output register.
// A sync byte inside an open packet restarts it without a report.
// Reset closes any open packet, clears the output valid and loads threshold 15.
// When the receiver stalls, the output word holds, the input register keeps
// its byte, and in_chan.ready drops while that register is full and the
// output word is still waiting.
// ----------------------------------------------------------------------------
`include "tablet_packet_deframe_decode_defines.svh"

module tablet_packet_deframe_decode (
  input  logic                         clk,
  input  logic                         rst_n,
  tpdd_byte_if.sink                    in_chan,
  tpdd_report_if.source                out_chan,
  input  logic                         cfg_wr_en,
  input  logic [tpdd_pkg::PRESS_W-1:0] cfg_wr_data
);
  import tpdd_pkg::*;

  logic               in_vld_r;
  pkt_byte_t          in_byte_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   idx_nxt;
  pkt_byte_t          store_r [STORE_DEPTH];
  logic [PRESS_W-1:0] thresh_r;
  logic               out_vld_r;
  report_t            out_r;

  logic               s2_free;
  logic               proc;
  logic               is_sync;
  logic               is_stray;
  logic               is_last;
  logic [IDX_W-1:0]   wr_idx;
  packet_t            packet;
  report_t            dec_report;
  report_t            out_nxt;

  assign s2_free      = !out_vld_r || out_chan.ready;
  assign proc         = in_vld_r && s2_free;
  assign in_chan.ready = !in_vld_r || s2_free;

  assign is_sync  = in_byte_r[SYNC_BIT];
  assign is_stray = !is_sync && (idx_r == IDX_IDLE);
  assign is_last  = !is_sync && (idx_r == IDX_LAST);
  assign wr_idx   = is_sync ? IDX_IDLE : idx_r;

  always_comb begin
    for (int k = 0; k < STORE_DEPTH; k++) begin
      packet[k] = store_r[k];
    end
    packet[PACKET_BYTES-1] = in_byte_r;
  end

  tpdd_report_decode u_decode (
    .packet    (packet),
    .threshold (thresh_r),
    .report    (dec_report)
  );

  always_comb begin
    priority if (is_sync) begin
      idx_nxt = IDX_W'(1);
    end else if (is_stray || is_last) begin
      idx_nxt = IDX_IDLE;
    end else begin
      idx_nxt = idx_r + IDX_W'(1);
    end

    if (is_stray) begin
      out_nxt               = '0;
      out_nxt.framing_error = 1'b1;
    end else begin
      out_nxt = dec_report;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      idx_r     <= IDX_IDLE;
      out_vld_r <= 1'b0;
      thresh_r  <= THRESH_RESET;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        in_vld_r <= 1'b1;
      end else if (proc) begin
        in_vld_r <= 1'b0;
      end

      if (proc) begin
        idx_r <= idx_nxt;
      end

      if (proc && (is_stray || is_last)) begin
        out_vld_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_vld_r <= 1'b0;
      end

      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.rx_byte;
    end
    if (proc && !is_stray) begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
        if (wr_idx == IDX_W'(k)) begin
          store_r[k] <= in_byte_r;
        end
      end
    end
    if (proc && (is_stray || is_last)) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.x_position    = out_r.x_position;
  assign out_chan.y_position    = out_r.y_position;
  assign out_chan.pressure      = out_r.pressure;
  assign out_chan.left_button   = out_r.left_button;
  assign out_chan.right_button  = out_r.right_button;
  assign out_chan.in_proximity  = out_r.in_proximity;
  assign out_chan.framing_error = out_r.framing_error;

  `TPDD_ASSERT(a_idx_range, clk, rst_n, idx_r <= IDX_LAST, "byte index past last packet byte")
  `TPDD_ASSERT(a_sync_opens, clk, rst_n, proc && is_sync |=> idx_r == IDX_W'(1), "sync byte did not open a packet")
  `TPDD_ASSERT(a_err_clean, clk, rst_n, out_vld_r && out_r.framing_error |-> out_r.x_position == '0 && out_r.y_position == '0 && out_r.pressure == '0 && !out_r.left_button && !out_r.right_button && !out_r.in_proximity, "framing error word carries data")
  `TPDD_ASSERT(a_result_loaded, clk, rst_n, proc && (is_stray || is_last) |=> out_vld_r, "result word lost")

endmodule
